// ===== hdl/sss_pkg.sv =====
`timescale 1ns / 1ps

package sss_pkg;

  // Field widths
  localparam int unsigned OFFSET_W = 32;
  localparam int unsigned DEPTH_W  = 8;
  localparam int unsigned CLASS_W  = 2;
  localparam int unsigned ERR_W    = 3;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 48;

  // Saturation limit of the nesting depth
  localparam logic [DEPTH_W-1:0] MAX_DEPTH = 8'd255;

  // Characters of interest
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_NL    = 8'h0A;

  typedef enum logic [CLASS_W-1:0] {
    CLS_CODE    = 2'd0,
    CLS_QUOTE   = 2'd1,
    CLS_APOS    = 2'd2,
    CLS_COMMENT = 2'd3
  } sss_class_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE        = 3'd0,
    ERR_QUOTE_APOS  = 3'd1,
    ERR_STRAY_CLOSE = 3'd2,
    ERR_OVERFLOW    = 3'd3,
    ERR_UNCLOSED    = 3'd4
  } sss_err_t;

  // One registered input byte
  typedef struct packed {
    logic                 last;
    logic [IN_DATA_W-1:0] data_byte;
  } sss_item_t;

  // One result, fields listed from the highest bit down as on the output bus
  typedef struct packed {
    logic             pad;
    sss_err_t         error_code;
    sss_class_t       literal_class;
    logic             node_closed;
    logic             node_opened;
    logic [DEPTH_W-1:0]  depth_after;
    logic [OFFSET_W-1:0] offset;
  } sss_result_t;

  // Class of a set of scope flags; comment wins over apostrophe over quote
  function automatic sss_class_t class_of(logic q, logic a, logic c);
    sss_class_t cls;
    if (c) begin
      cls = CLS_COMMENT;
    end else if (a) begin
      cls = CLS_APOS;
    end else if (q) begin
      cls = CLS_QUOTE;
    end else begin
      cls = CLS_CODE;
    end
    return cls;
  endfunction

endpackage

// ===== hdl/sss_in_stage.sv =====
`timescale 1ns / 1ps

module sss_in_stage import sss_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  sss_item_t in_item,
  output logic      item_valid,
  output sss_item_t item,
  input  logic      item_take
);

  logic      valid_r;
  sss_item_t item_r;

  // Accept a new byte when the register is empty or is being drained
  assign in_tready  = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  // Hold the input byte until the scanner takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== hdl/sss_scan_core.sv =====
`timescale 1ns / 1ps

module sss_scan_core import sss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  sss_item_t   item,
  input  logic        res_ready,
  output logic        item_take,
  output sss_result_t result
);

  logic [DEPTH_W-1:0]  depth_r, depth_nxt;
  logic [OFFSET_W-1:0] count_r, count_nxt;
  logic quote_r, quote_nxt;
  logic apos_r, apos_nxt;
  logic comment_r, comment_nxt;

  logic       opened, closed;
  sss_err_t   err;
  sss_class_t cls_before, cls_after;
  logic [7:0] ch;

  assign item_take = item_valid && res_ready;
  assign ch        = item.data_byte;

  // Scope and depth update for one byte
  always_comb begin
    depth_nxt   = depth_r;
    quote_nxt   = quote_r;
    apos_nxt    = apos_r;
    comment_nxt = comment_r;
    opened      = 1'b0;
    closed      = 1'b0;
    err         = ERR_NONE;
    if (comment_r) begin
      if (ch == CH_NL) begin
        comment_nxt = 1'b0;
      end
    end else if (ch == CH_QUOTE) begin
      if (apos_r) begin
        err = ERR_QUOTE_APOS;
      end else begin
        quote_nxt = !quote_r;
      end
    end else if (!quote_r) begin
      if (!apos_r) begin
        if (ch == CH_OPEN) begin
          if (depth_r >= MAX_DEPTH) begin
            depth_nxt = MAX_DEPTH;
            err       = ERR_OVERFLOW;
          end else begin
            depth_nxt = depth_r + 1'b1;
            opened    = 1'b1;
          end
        end else if (ch == CH_CLOSE) begin
          if (depth_r == '0) begin
            err = ERR_STRAY_CLOSE;
          end else begin
            depth_nxt = depth_r - 1'b1;
            closed    = 1'b1;
          end
        end else if (ch == CH_APOS) begin
          apos_nxt = 1'b1;
        end else if (ch == CH_SEMI) begin
          comment_nxt = 1'b1;
        end
      end else if (ch == CH_APOS) begin
        apos_nxt = 1'b0;
      end
    end

    // Delimiters take the class of the literal they open or close
    cls_before = class_of(quote_r, apos_r, comment_r);
    cls_after  = class_of(quote_nxt, apos_nxt, comment_nxt);
    if (cls_after == CLS_CODE) begin
      cls_after = cls_before;
    end

    // Flag a stream that ends inside a node, unless the byte already has an error
    if (item.last && depth_nxt != '0 && err == ERR_NONE) begin
      err = ERR_UNCLOSED;
    end

    count_nxt = count_r + 1'b1;
  end

  // Assemble the result for the output register
  always_comb begin
    result               = '0;
    result.offset        = count_r;
    result.depth_after   = depth_nxt;
    result.node_opened   = opened;
    result.node_closed   = closed;
    result.literal_class = cls_after;
    result.error_code    = err;
  end

  // Advance scan state on each taken byte; clear it at the end of a stream
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r   <= '0;
      count_r   <= '0;
      quote_r   <= 1'b0;
      apos_r    <= 1'b0;
      comment_r <= 1'b0;
    end else if (item_take) begin
      if (item.last) begin
        depth_r   <= '0;
        count_r   <= '0;
        quote_r   <= 1'b0;
        apos_r    <= 1'b0;
        comment_r <= 1'b0;
      end else begin
        depth_r   <= depth_nxt;
        count_r   <= count_nxt;
        quote_r   <= quote_nxt;
        apos_r    <= apos_nxt;
        comment_r <= comment_nxt;
      end
    end
  end

  // At most one literal scope is open at a time
  a_one_scope: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({quote_r, apos_r, comment_r}))
    else $error("more than one literal scope open");

  // Depth never passes the saturation limit
  a_depth_limit: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= MAX_DEPTH)
    else $error("nesting depth above limit");

  // The end of a stream leaves the scanner in its reset state
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && item.last |=> depth_r == '0 && count_r == '0 &&
      !quote_r && !apos_r && !comment_r)
    else $error("scan state not cleared after end of stream");

  // A byte never both opens and closes a node
  a_open_close: assert property (@(posedge clk) disable iff (!rst_n)
    item_take |-> !(opened && closed))
    else $error("byte both opened and closed a node");

endmodule

// ===== hdl/sss_out_stage.sv =====
`timescale 1ns / 1ps

module sss_out_stage import sss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_valid,
  input  sss_result_t res,
  output logic        res_ready,
  output logic        out_tvalid,
  input  logic        out_tready,
  output sss_result_t out_res
);

  logic        valid_r;
  sss_result_t res_r;

  // Load a new result when empty or when the held one is transferred
  assign res_ready  = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

endmodule

// ===== hdl/sexpr_scope_scanner_unit.sv =====
`timescale 1ns / 1ps

// S-expression scope scanner: takes one text byte per transfer and returns one
// result per byte, in order, with the byte offset, the nesting depth after the
// byte, open/close marks, the literal class (code, double quote, apostrophe,
// comment) and an error code. Throughput is one byte per clock cycle while the
// output is not held off, set by the combinational depth and scope-flag update;
// each byte passes the input register, then the result register, which loads
// only when the held result is transferred or the register is empty. A byte
// with in_tlast set ends the stream: depth, flags and offset return to zero.
// No initialisation pass is needed after reset.
module sexpr_scope_scanner_unit import sss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                  in_tlast,   // end_of_data
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [31:0] offset, [39:32] depth_after,
                                            // [40] node_opened, [41] node_closed,
                                            // [43:42] literal_class,
                                            // [46:44] error_code, [47] zero
);

  sss_item_t   in_item, item;
  sss_result_t result, out_res;
  logic        item_valid, item_take, res_ready;

  assign in_item.data_byte = in_tdata;
  assign in_item.last      = in_tlast;

  sss_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  sss_scan_core u_scan_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .res_ready  (res_ready),
    .item_take  (item_take),
    .result     (result)
  );

  sss_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (item_valid),
    .res        (result),
    .res_ready  (res_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = out_res;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb import sss_pkg::*; ();

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned RANDOM_BYTES   = 1100;
  localparam int unsigned HOLD_CYCLES    = 250;
  localparam int unsigned HOLD_AFTER     = 700;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  sexpr_scope_scanner_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // One row of the directed stimulus; want is used only where checked is set
  typedef struct {
    logic [7:0]  b;
    logic        last;
    int unsigned reps;
    bit          checked;
    sss_result_t want;
  } scan_row_t;

  // Scanner state mirrored by the predictor
  logic [DEPTH_W-1:0]  scan_depth;
  logic                in_quote;
  logic                in_apos;
  logic                in_comment;
  logic [OFFSET_W-1:0] scan_offset;

  sss_result_t pending_scan_results[$];
  scan_row_t   directed_rows[$];
  logic [7:0]  text_q[$];

  int unsigned scan_fails;
  int unsigned bytes_sent;
  int unsigned idle_cycles;
  bit          tx_burst;
  bit          rx_held;
  bit          deep_done;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned stall_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic void reset_scan();
    scan_depth  = '0;
    in_quote    = 1'b0;
    in_apos     = 1'b0;
    in_comment  = 1'b0;
    scan_offset = '0;
  endfunction

  // Comment outranks apostrophe, apostrophe outranks quote
  function automatic sss_class_t scope_class();
    if (in_comment) return CLS_COMMENT;
    if (in_apos) return CLS_APOS;
    if (in_quote) return CLS_QUOTE;
    return CLS_CODE;
  endfunction

  // Predict the result of one byte and advance the mirrored state
  function automatic sss_result_t scan_byte(logic [7:0] b, logic last);
    sss_result_t r;
    sss_class_t  entry_cls;
    sss_class_t  exit_cls;
    r            = '0;
    r.offset     = scan_offset;
    r.error_code = ERR_NONE;
    entry_cls    = scope_class();
    if (in_comment) begin
      if (b == CH_NL) in_comment = 1'b0;
    end else if (b == CH_QUOTE) begin
      if (in_apos) r.error_code = ERR_QUOTE_APOS;
      else in_quote = ~in_quote;
    end else if (!in_quote) begin
      if (!in_apos) begin
        case (b)
          CH_OPEN: begin
            if (scan_depth >= MAX_DEPTH) begin
              scan_depth   = MAX_DEPTH;
              r.error_code = ERR_OVERFLOW;
            end else begin
              scan_depth    = scan_depth + 1'b1;
              r.node_opened = 1'b1;
            end
          end
          CH_CLOSE: begin
            if (scan_depth == '0) begin
              r.error_code = ERR_STRAY_CLOSE;
            end else begin
              scan_depth    = scan_depth - 1'b1;
              r.node_closed = 1'b1;
            end
          end
          CH_APOS: in_apos = 1'b1;
          CH_SEMI: in_comment = 1'b1;
          default: ;
        endcase
      end else if (b == CH_APOS) begin
        in_apos = 1'b0;
      end
    end
    // Delimiters take the class of the literal they open or close
    exit_cls        = scope_class();
    r.literal_class = (exit_cls == CLS_CODE) ? entry_cls : exit_cls;
    if (last && scan_depth != '0 && r.error_code == ERR_NONE) r.error_code = ERR_UNCLOSED;
    r.depth_after = scan_depth;
    if (last) reset_scan();
    else scan_offset = scan_offset + 1'b1;
    return r;
  endfunction

  function automatic void add_row(logic [7:0] b, logic last, int unsigned reps);
    scan_row_t row;
    row.b       = b;
    row.last    = last;
    row.reps    = reps;
    row.checked = 1'b0;
    row.want    = '0;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic void add_checked_row(logic [7:0] b, logic last, logic [31:0] off,
                                          logic [7:0] depth, logic op, logic cl,
                                          sss_class_t cls, sss_err_t err);
    scan_row_t row;
    row.b                  = b;
    row.last               = last;
    row.reps               = 1;
    row.checked            = 1'b1;
    row.want               = '0;
    row.want.offset        = off;
    row.want.depth_after   = depth;
    row.want.node_opened   = op;
    row.want.node_closed   = cl;
    row.want.literal_class = cls;
    row.want.error_code    = err;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      scan_fails++;
    end
  endfunction

  // Offer one byte, hold it until the transfer, then queue its expected result
  task automatic push_byte(logic [7:0] b, logic last, bit checked, sss_result_t want);
    sss_result_t predicted;
    int unsigned gap;
    in_tdata  <= b;
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predicted = scan_byte(b, last);
    pending_scan_results.insert(pending_scan_results.size(), checked ? want : predicted);
    bytes_sent++;
    gap = (!tx_burst && $urandom_range(0, 2) == 0) ? stall_len() : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] letter();
    return 8'($urandom_range(8'h61, 8'h7a));
  endfunction

  // Append one byte to the stream under construction
  function automatic void put_text(logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  // Build one stream of text: mostly nested nodes with literals and comments
  function automatic void build_stream();
    int unsigned kind;
    int unsigned n;
    int unsigned gen_depth;
    int unsigned tok;
    kind = $urandom_range(0, 9);
    text_q.delete();
    gen_depth = 0;
    if (kind == 0) begin
      // Noise: any byte value
      n = $urandom_range(1, 24);
      repeat (n) put_text(8'($urandom_range(0, 255)));
    end else if (kind == 1 && !deep_done) begin
      // Deep nesting up to or past the saturation limit
      deep_done = 1'b1;
      repeat ($urandom_range(250, 262)) put_text(CH_OPEN);
      repeat ($urandom_range(0, 262)) put_text(CH_CLOSE);
    end else begin
      n = $urandom_range(4, 60);
      repeat (n) begin
        tok = $urandom_range(0, 9);
        case (tok) inside
          [0:1]: begin
            put_text(CH_OPEN);
            gen_depth++;
          end
          [2:3]: begin
            if (gen_depth > 0) begin
              put_text(CH_CLOSE);
              gen_depth--;
            end else begin
              put_text(letter());
            end
          end
          4: begin
            put_text(CH_QUOTE);
            repeat ($urandom_range(0, 6)) put_text(letter());
            put_text(CH_QUOTE);
          end
          5: begin
            put_text(CH_APOS);
            repeat ($urandom_range(0, 6)) put_text(letter());
            put_text(CH_APOS);
          end
          6: begin
            put_text(CH_SEMI);
            repeat ($urandom_range(0, 8)) put_text(letter());
            put_text(CH_NL);
          end
          7: put_text($urandom_range(0, 1) ? 8'h20 : CH_NL);
          default: begin
            repeat ($urandom_range(1, 5)) begin
              if ($urandom_range(0, 9) == 0) put_text(8'($urandom_range(0, 255)));
              else put_text(letter());
            end
          end
        endcase
      end
      // Mostly close every node; sometimes leave nodes open or add a stray close
      case ($urandom_range(0, 5))
        0: ;
        1: repeat (gen_depth + 1) put_text(CH_CLOSE);
        default: repeat (gen_depth) put_text(CH_CLOSE);
      endcase
      if (text_q.size() == 0) put_text(letter());
    end
  endfunction

  // Stimulus
  initial begin : stimulus
    int unsigned random_sent;
    bit          noisy;
    logic        last;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    rst_n       = 1'b0;
    scan_fails  = 0;
    bytes_sent  = 0;
    deep_done   = 1'b0;
    random_sent = 0;
    reset_scan();

    // Plain nodes, stray close, quote inside apostrophes
    add_checked_row(CH_OPEN, 1'b0, 0, 1, 1'b1, 1'b0, CLS_CODE, ERR_NONE);
    add_row(CH_CLOSE, 1'b0, 1);
    add_checked_row(CH_CLOSE, 1'b0, 2, 0, 1'b0, 1'b0, CLS_CODE, ERR_STRAY_CLOSE);
    add_row(CH_APOS, 1'b0, 1);
    add_checked_row(CH_QUOTE, 1'b0, 4, 0, 1'b0, 1'b0, CLS_APOS, ERR_QUOTE_APOS);
    add_row(CH_OPEN, 1'b0, 1);
    add_row(CH_APOS, 1'b0, 1);
    // Double-quoted literal holding a semicolon, then a comment
    add_row(CH_QUOTE, 1'b0, 1);
    add_row(CH_SEMI, 1'b0, 1);
    add_row(CH_OPEN, 1'b0, 1);
    add_row(CH_QUOTE, 1'b0, 1);
    add_row(CH_SEMI, 1'b0, 1);
    add_row(CH_OPEN, 1'b0, 1);
    add_row(CH_QUOTE, 1'b0, 1);
    add_row(CH_NL, 1'b0, 1);
    // Byte extremes, then end of stream with a node still open
    add_checked_row(8'hFF, 1'b0, 15, 0, 1'b0, 1'b0, CLS_CODE, ERR_NONE);
    add_row(8'h00, 1'b0, 1);
    add_checked_row(CH_OPEN, 1'b1, 17, 1, 1'b1, 1'b0, CLS_CODE, ERR_UNCLOSED);
    add_checked_row(CH_CLOSE, 1'b1, 0, 0, 1'b0, 1'b0, CLS_CODE, ERR_STRAY_CLOSE);
    // Saturate the depth; overflow outranks unclosed at end
    add_row(CH_OPEN, 1'b0, 255);
    add_checked_row(CH_OPEN, 1'b0, 255, 255, 1'b0, 1'b0, CLS_CODE, ERR_OVERFLOW);
    add_checked_row(CH_OPEN, 1'b1, 256, 255, 1'b0, 1'b0, CLS_CODE, ERR_OVERFLOW);
    add_row(CH_NL, 1'b1, 1);
    // Quote inside apostrophes outranks unclosed at end
    add_row(CH_OPEN, 1'b0, 1);
    add_row(CH_APOS, 1'b0, 1);
    add_checked_row(CH_QUOTE, 1'b1, 2, 1, 1'b0, 1'b0, CLS_APOS, ERR_QUOTE_APOS);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part
    tx_burst = 1'b0;
    foreach (directed_rows[i]) begin
      repeat (directed_rows[i].reps)
        push_byte(directed_rows[i].b, directed_rows[i].last, directed_rows[i].checked,
                  directed_rows[i].want);
    end

    // Pause until every result is back
    in_tvalid <= 1'b0;
    while (pending_scan_results.size() != 0) @(posedge clk);

    // Random streams
    while (random_sent < RANDOM_BYTES) begin
      build_stream();
      tx_burst = ($urandom_range(0, 3) == 0);
      noisy    = ($urandom_range(0, 7) == 0);
      foreach (text_q[i]) begin
        last = (i == text_q.size() - 1);
        if (noisy) last = ($urandom_range(0, 9) == 0);
        push_byte(text_q[i], last, 1'b0, '0);
        random_sent++;
      end
    end

    // Drain
    in_tvalid <= 1'b0;
    while (pending_scan_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (scan_fails == 0 && pending_scan_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result receiver: random stalls, calm stretches and one long hold-off
  initial begin : receiver
    bit rx_busy;
    out_tready = 1'b0;
    rx_held    = 1'b0;
    rx_busy    = 1'b1;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!rx_held && bytes_sent >= HOLD_AFTER) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_held = 1'b1;
      end else if (rx_busy && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (stall_len()) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) rx_busy = ~rx_busy;
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    sss_result_t got;
    sss_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_scan_results.size() == 0) begin
        $error("unexpected result transfer: %h", out_tdata);
        scan_fails++;
      end else begin
        want = pending_scan_results.pop_front();
        cmp_field("offset", want.offset, got.offset);
        cmp_field("depth_after", want.depth_after, got.depth_after);
        cmp_field("node_opened", want.node_opened, got.node_opened);
        cmp_field("node_closed", want.node_closed, got.node_closed);
        cmp_field("literal_class", want.literal_class, got.literal_class);
        cmp_field("error_code", want.error_code, got.error_code);
        cmp_field("pad", 1'b0, got.pad);
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== filelist.f =====
hdl/sss_pkg.sv
hdl/sss_in_stage.sv
hdl/sss_scan_core.sv
hdl/sss_out_stage.sv
hdl/sexpr_scope_scanner_unit.sv
bench/tb.sv
